// File: sv/aoc_pkg.sv
// aoc_pkg: shared widths, types and constants for the alpha-over compositor.
// No dependencies; imported by every module of the block.

package aoc_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int CH_BITS         = 8;
    localparam int LANES           = 3;
    localparam int PIX_BITS        = 2 * (LANES + 1) * CH_BITS;
    localparam int DEN_BITS        = 2 * CH_BITS;
    localparam int NUM_BITS        = 3 * CH_BITS;
    localparam int DIV_STAGES      = CH_BITS;
    localparam int ALPHA_PROD_BITS = 32;
    localparam int RECIP_SHIFT     = 23;
    localparam int CFG_DATA_BITS   = 12;
    localparam int CFG_INDEX_BITS  = 1;

    typedef logic [CH_BITS-1:0]        chan_t;
    typedef logic [DEN_BITS-1:0]       den_t;
    typedef logic [NUM_BITS-1:0]       num_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam chan_t CHAN_MAX  = '1;
    // ceil(2^23 / 255): x / 255 == (x * RECIP_255) >> 23 for x <= 255 * 255
    localparam den_t  RECIP_255 = 16'h8081;

    localparam cfg_index_t CFG_OFFSET_X = 1'b0;
    localparam cfg_index_t CFG_OFFSET_Y = 1'b1;

    typedef struct packed {
        logic  valid;
        logic  zero;
        chan_t alpha;
    } aoc_side_t;

endpackage

// File: sv/aoc_lane.sv
// aoc_lane: one color channel: weighted numerator and an 8-stage restoring divider.
// Depends on aoc_pkg; divisor per stage comes from aoc_front.

module aoc_lane
    import aoc_pkg::*;
(
    input  logic  aclk,
    input  logic  adv,
    input  chan_t src_chan,
    input  chan_t dst_chan,
    input  chan_t src_alpha,
    input  den_t  wd_s1,
    input  den_t  den_pipe [DIV_STAGES],
    output chan_t quot
);

    den_t  csa_reg;
    chan_t cd_s1_reg;
    num_t  num_reg;
    num_t  num_next;
    num_t  csa_ext;
    num_t  cd_wd;
    num_t  rem_reg [DIV_STAGES];
    chan_t q_reg   [DIV_STAGES];

    assign csa_ext  = NUM_BITS'(csa_reg);
    assign cd_wd    = NUM_BITS'(cd_s1_reg) * NUM_BITS'(wd_s1);
    assign num_next = (csa_ext << CH_BITS) - csa_ext + cd_wd;

    always_ff @(posedge aclk) begin
        if (adv) begin
            csa_reg   <= DEN_BITS'(src_chan) * DEN_BITS'(src_alpha);
            cd_s1_reg <= dst_chan;
            num_reg   <= num_next;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        localparam int SH = DIV_STAGES - 1 - k;
        num_t              rem_in;
        chan_t             q_in;
        logic [NUM_BITS:0] trial;
        num_t              rem_next;
        chan_t             q_next;

        if (k == 0) begin : g_first
            assign rem_in = num_reg;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign trial    = {1'b0, rem_in} - ({1'b0, NUM_BITS'(den_pipe[k])} << SH);
        assign rem_next = trial[NUM_BITS] ? rem_in : trial[NUM_BITS-1:0];
        assign q_next   = {q_in[CH_BITS-2:0], ~trial[NUM_BITS]};

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
            end
        end
    end

    assign quot = q_reg[DIV_STAGES-1];

endmodule

// File: sv/aoc_front.sv
// aoc_front: shared pipeline: alpha weights, divisor, output alpha, coordinates.
// Depends on aoc_pkg; feeds the lanes and aoc_merge.

module aoc_front
    import aoc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int SUM_BITS = COORD_BITS + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  chan_t                 src_alpha,
    input  chan_t                 dst_alpha,
    input  logic [COORD_BITS-1:0] src_row,
    input  logic [COORD_BITS-1:0] src_col,
    input  logic [COORD_BITS-1:0] offset_x,
    input  logic [COORD_BITS-1:0] offset_y,
    output den_t                  wd_s1,
    output den_t                  den_pipe [DIV_STAGES],
    output aoc_side_t             side,
    output logic [SUM_BITS-1:0]   dest_row,
    output logic [SUM_BITS-1:0]   dest_col
);

    logic                       v_s1_reg;
    logic                       v_s2_reg;
    chan_t                      sa_s1_reg;
    chan_t                      sa_s2_reg;
    den_t                       wd_s1_reg;
    den_t                       as255_s1_reg;
    chan_t                      aq_s2_reg;
    logic [SUM_BITS-1:0]        row_s1_reg;
    logic [SUM_BITS-1:0]        col_s1_reg;
    logic [SUM_BITS-1:0]        row_s2_reg;
    logic [SUM_BITS-1:0]        col_s2_reg;
    den_t                       den_pipe_reg [DIV_STAGES];
    aoc_side_t                  side_reg     [DIV_STAGES];
    logic [SUM_BITS-1:0]        row_d_reg    [DIV_STAGES];
    logic [SUM_BITS-1:0]        col_d_reg    [DIV_STAGES];
    logic [ALPHA_PROD_BITS-1:0] aprod;
    den_t                       sa_ext;
    aoc_side_t                  side_next;

    assign sa_ext = DEN_BITS'(src_alpha);
    assign aprod  = ALPHA_PROD_BITS'(wd_s1_reg) * ALPHA_PROD_BITS'(RECIP_255);

    always_comb begin
        side_next.valid = v_s2_reg;
        side_next.zero  = (den_pipe_reg[0] == '0);
        side_next.alpha = sa_s2_reg + aq_s2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_s1_reg <= 1'b0;
            v_s2_reg <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++) begin
                side_reg[k] <= '0;
            end
        end else if (adv) begin
            v_s1_reg    <= in_valid;
            v_s2_reg    <= v_s1_reg;
            side_reg[0] <= side_next;
            for (int k = 1; k < DIV_STAGES; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sa_s1_reg       <= src_alpha;
            wd_s1_reg       <= DEN_BITS'(dst_alpha) * DEN_BITS'(CHAN_MAX - src_alpha);
            as255_s1_reg    <= (sa_ext << CH_BITS) - sa_ext;
            row_s1_reg      <= SUM_BITS'(src_row) + SUM_BITS'(offset_y);
            col_s1_reg      <= SUM_BITS'(src_col) + SUM_BITS'(offset_x);
            sa_s2_reg       <= sa_s1_reg;
            aq_s2_reg       <= aprod[RECIP_SHIFT +: CH_BITS];
            den_pipe_reg[0] <= as255_s1_reg + wd_s1_reg;
            row_s2_reg      <= row_s1_reg;
            col_s2_reg      <= col_s1_reg;
            row_d_reg[0]    <= row_s2_reg;
            col_d_reg[0]    <= col_s2_reg;
            for (int k = 1; k < DIV_STAGES; k++) begin
                den_pipe_reg[k] <= den_pipe_reg[k-1];
                row_d_reg[k]    <= row_d_reg[k-1];
                col_d_reg[k]    <= col_d_reg[k-1];
            end
        end
    end

    assign wd_s1    = wd_s1_reg;
    assign den_pipe = den_pipe_reg;
    assign side     = side_reg[DIV_STAGES-1];
    assign dest_row = row_d_reg[DIV_STAGES-1];
    assign dest_col = col_d_reg[DIV_STAGES-1];

endmodule

// File: sv/aoc_merge.sv
// aoc_merge: joins the lane quotients with alpha and coordinates into one beat,
// output register plus skid register. Depends on aoc_pkg.

module aoc_merge
    import aoc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int SUM_BITS = COORD_BITS + 1,
    localparam int BEAT_BITS = (LANES + 1) * CH_BITS + 2 * SUM_BITS,
    localparam int M_DATA_BITS = ((BEAT_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  aoc_side_t              side,
    input  chan_t                  quot [LANES],
    input  logic [SUM_BITS-1:0]    dest_row,
    input  logic [SUM_BITS-1:0]    dest_col,
    output logic                   in_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata
);

    logic [LANES*CH_BITS-1:0] color;
    logic [BEAT_BITS-1:0]     beat;
    logic                     in_fire;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [BEAT_BITS-1:0]     out_data_reg;
    logic [BEAT_BITS-1:0]     out_data_next;
    logic                     skid_valid_reg;
    logic                     skid_valid_next;
    logic [BEAT_BITS-1:0]     skid_data_reg;
    logic [BEAT_BITS-1:0]     skid_data_next;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            color[l*CH_BITS +: CH_BITS] = side.zero ? '0 : quot[l];
        end
        beat = {dest_col, dest_row, side.alpha, color};
    end

    assign in_ready = !skid_valid_reg;
    assign in_fire  = side.valid && in_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_fire;
                out_data_next  = beat;
            end
        end else if (in_fire) begin
            skid_valid_next = 1'b1;
            skid_data_next  = beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_BITS'(out_data_reg);

endmodule

// File: sv/alpha_over_compositor_unit.sv
// alpha_over_compositor_unit: Porter-Duff over of non-premultiplied RGBA8 pixels.
// Depends on aoc_pkg, aoc_front, aoc_lane, aoc_merge.
//
// Usage:
//   s_ channel: one beat per pixel pair (source RGBA, background RGBA, source
//   row and column). m_ channel: one beat per input beat, in order, carrying
//   the composited RGBA and the destination row and column (source position
//   plus the paste offset). Offsets are written over the cfg_ port while the
//   block is idle; index CFG_OFFSET_X is the column offset, CFG_OFFSET_Y the row.
//   Throughput: one beat per cycle while the skid register is empty. A beat
//   passes through two weighting stages (the first loaded at the accepting
//   edge), eight divider stages (one quotient bit each, the three color lanes
//   side by side) and the output register before it shows on m_tvalid.
//   The pipeline advances while the skid register is empty, so when m_tready
//   drops the output register holds its beat, one more beat lands in the skid
//   register and s_tready then goes low until the output drains.
//   Reset clears both offsets and every valid flag; no beat is output and
//   s_tready is high in the first cycle after reset.

module alpha_over_compositor_unit
    import aoc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int SUM_BITS = COORD_BITS + 1,
    localparam int S_DATA_BITS = ((PIX_BITS + 2 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_BITS = (((LANES + 1) * CH_BITS + 2 * SUM_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue,
    // dst_alpha, src_row, src_col, zero pad
    input  logic [S_DATA_BITS-1:0]   s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // out_red, out_green, out_blue, out_alpha, dest_row, dest_col, zero pad
    output logic [M_DATA_BITS-1:0]   m_tdata,
    input  logic                     cfg_wr_en,
    input  cfg_index_t               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wr_data
);

    logic [COORD_BITS-1:0] offset_x_reg;
    logic [COORD_BITS-1:0] offset_y_reg;
    logic                  adv;
    den_t                  wd_s1;
    den_t                  den_pipe [DIV_STAGES];
    aoc_side_t             side;
    logic [SUM_BITS-1:0]   dest_row;
    logic [SUM_BITS-1:0]   dest_col;
    chan_t                 quot [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_OFFSET_X: offset_x_reg <= COORD_BITS'(cfg_wr_data);
                CFG_OFFSET_Y: offset_y_reg <= COORD_BITS'(cfg_wr_data);
                default: ;
            endcase
        end
    end

    assign s_tready = adv;

    aoc_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .src_alpha (s_tdata[LANES*CH_BITS +: CH_BITS]),
        .dst_alpha (s_tdata[(2*LANES+1)*CH_BITS +: CH_BITS]),
        .src_row   (s_tdata[PIX_BITS +: COORD_BITS]),
        .src_col   (s_tdata[PIX_BITS+COORD_BITS +: COORD_BITS]),
        .offset_x  (offset_x_reg),
        .offset_y  (offset_y_reg),
        .wd_s1     (wd_s1),
        .den_pipe  (den_pipe),
        .side      (side),
        .dest_row  (dest_row),
        .dest_col  (dest_col)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        aoc_lane u_lane (
            .aclk      (aclk),
            .adv       (adv),
            .src_chan  (s_tdata[l*CH_BITS +: CH_BITS]),
            .dst_chan  (s_tdata[(LANES+1+l)*CH_BITS +: CH_BITS]),
            .src_alpha (s_tdata[LANES*CH_BITS +: CH_BITS]),
            .wd_s1     (wd_s1),
            .den_pipe  (den_pipe),
            .quot      (quot[l])
        );
    end

    aoc_merge #(
        .COORD_BITS(COORD_BITS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .side     (side),
        .quot     (quot),
        .dest_row (dest_row),
        .dest_col (dest_col),
        .in_ready (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: sv/aoc_checker.sv
// aoc_checker: port-level checks for alpha_over_compositor_unit, bound to the top.
// Depends on aoc_pkg.

module aoc_checker
    import aoc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int M_DATA_BITS = (((LANES + 1) * CH_BITS + 2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_DATA_BITS-1:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output beat present after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    a_clear_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[LANES*CH_BITS +: CH_BITS] == '0)
            |-> (m_tdata[LANES*CH_BITS-1:0] == '0))
        else $error("color nonzero at zero alpha");

endmodule

bind alpha_over_compositor_unit aoc_checker #(
    .COORD_BITS(COORD_BITS)
) u_aoc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
